@@ sv/esd_pkg.sv @@
`timescale 1ns / 1ps

package esd_pkg;

   localparam int CHAR_WIDTH  = 8;
   localparam int MAX_RESULTS = 3;
   localparam int QUEUE_DEPTH = 4;

   // Escape parser modes; unused codes fall back to normal text.
   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_ESC    = 3'd1,
      MODE_DIG1   = 3'd2,
      MODE_DIG2   = 3'd3,
      MODE_HEX1   = 3'd4,
      MODE_HEX2   = 3'd5
   } parse_mode_type;

   typedef logic [CHAR_WIDTH-1:0] char_type;
   typedef logic [1:0]            res_count_type;
   typedef logic [2:0]            level_type;

   typedef struct packed {
      parse_mode_type mode;
      char_type       held_first;
      char_type       held_second;
   } parse_state_type;

   // Bytes produced by one text byte, in emit order from index 0.
   typedef struct packed {
      logic [MAX_RESULTS-1:0][CHAR_WIDTH-1:0] chars;
      res_count_type                          count;
      logic                                   eot;
   } dec_result_type;

   typedef struct packed {
      char_type char_out;
      logic     end_of_text;
   } rsp_item_type;

   typedef struct packed {
      level_type level;
      logic      ready;
   } queue_status_type;

endpackage

@@ sv/esd_ifs.sv @@
`timescale 1ns / 1ps

// Raw text byte channel.
interface esd_req_if;
   logic                  valid;
   logic                  ready;
   logic [7:0]            char_in;
   logic                  is_last;

   modport source (output valid, output char_in, output is_last, input ready);
   modport sink   (input valid, input char_in, input is_last, output ready);
endinterface

// Translated byte channel.
interface esd_rsp_if;
   logic                  valid;
   logic                  ready;
   logic [7:0]            char_out;
   logic                  end_of_text;

   modport source (output valid, output char_out, output end_of_text, input ready);
   modport sink   (input valid, input char_out, input end_of_text, output ready);
endinterface

@@ sv/esd_decode.sv @@
`timescale 1ns / 1ps

module esd_decode (
   input  esd_pkg::parse_state_type state,
   input  logic [7:0]               char_in,
   input  logic                     is_last,
   output esd_pkg::parse_state_type state_in,
   output esd_pkg::dec_result_type  result
);
   import esd_pkg::*;

   localparam char_type CHAR_BACKSLASH = 8'h5c;
   localparam char_type CHAR_X_LOWER   = 8'h78;

   logic          ctrl_hit;
   char_type      ctrl_code;
   logic          is_dec;
   logic          is_hex;
   logic [3:0]    cur_nib;
   logic [3:0]    first_nib;
   char_type      oct_value;
   char_type      hex_value;
   logic          take_plain;
   res_count_type cnt;

   // Map escape letters to control codes, either case.
   always_comb begin
      ctrl_hit  = 1'b1;
      ctrl_code = 8'h00;
      case (char_in | 8'h20)
         8'h61:   ctrl_code = 8'h07;
         8'h62:   ctrl_code = 8'h08;
         8'h66:   ctrl_code = 8'h0c;
         8'h6e:   ctrl_code = 8'h0a;
         8'h72:   ctrl_code = 8'h0d;
         8'h74:   ctrl_code = 8'h09;
         8'h76:   ctrl_code = 8'h0b;
         8'h65:   ctrl_code = 8'h1b;
         default: ctrl_hit  = 1'b0;
      endcase
   end

   // Classify the current byte and form the numeric values.
   always_comb begin
      is_dec = (char_in >= 8'h30) && (char_in <= 8'h39);
      is_hex = is_dec || ((char_in >= 8'h61) && (char_in <= 8'h66))
               || ((char_in >= 8'h41) && (char_in <= 8'h46));
      cur_nib   = is_dec ? char_in[3:0] : 4'(char_in[3:0] + 4'd9);
      first_nib = (state.held_first[6] == 1'b0) ? state.held_first[3:0]
                                                : 4'(state.held_first[3:0] + 4'd9);
      oct_value = {state.held_first[1:0], 6'b0}
                | {1'b0, state.held_second[3:0], 3'b0}
                | {4'b0, char_in[3:0]};
      hex_value = {first_nib, cur_nib};
   end

   // Advance the parser and collect the emitted bytes.
   always_comb begin
      state_in     = state;
      state_in.mode = MODE_NORMAL;
      result.chars = '0;
      cnt          = 2'd0;
      take_plain   = 1'b0;
      case (state.mode)
         MODE_ESC: begin
            if (ctrl_hit) begin
               result.chars[0] = ctrl_code;
               cnt             = 2'd1;
            end else if (is_dec && !is_last) begin
               state_in.held_first = char_in;
               state_in.mode       = MODE_DIG1;
            end else if ((char_in == CHAR_X_LOWER) && !is_last) begin
               state_in.mode = MODE_HEX1;
            end else begin
               result.chars[0] = char_in;
               cnt             = 2'd1;
            end
         end
         MODE_DIG1: begin
            if (is_dec && !is_last) begin
               state_in.held_second = char_in;
               state_in.mode        = MODE_DIG2;
            end else begin
               result.chars[0] = state.held_first;
               cnt             = 2'd1;
               take_plain      = 1'b1;
            end
         end
         MODE_DIG2: begin
            if (is_dec) begin
               result.chars[0] = oct_value;
               cnt             = 2'd1;
            end else begin
               result.chars[0] = state.held_first;
               result.chars[1] = state.held_second;
               cnt             = 2'd2;
               take_plain      = 1'b1;
            end
         end
         MODE_HEX1: begin
            if (is_hex && !is_last) begin
               state_in.held_first = char_in;
               state_in.mode       = MODE_HEX2;
            end else begin
               result.chars[0] = CHAR_X_LOWER;
               cnt             = 2'd1;
               take_plain      = 1'b1;
            end
         end
         MODE_HEX2: begin
            if (is_hex) begin
               result.chars[0] = hex_value;
               cnt             = 2'd1;
            end else begin
               result.chars[0] = CHAR_X_LOWER;
               result.chars[1] = state.held_first;
               cnt             = 2'd2;
               take_plain      = 1'b1;
            end
         end
         default: take_plain = 1'b1;
      endcase

      // Handle the current byte as normal text.
      if (take_plain) begin
         if ((char_in == CHAR_BACKSLASH) && !is_last) begin
            state_in.mode = MODE_ESC;
         end else begin
            result.chars[cnt] = char_in;
            cnt               = 2'(cnt + 2'd1);
         end
      end

      // Flush to reset state at end of text.
      if (is_last) begin
         state_in.mode        = MODE_NORMAL;
         state_in.held_first  = '0;
         state_in.held_second = '0;
      end
      result.count = cnt;
      result.eot   = is_last;
   end

endmodule

@@ sv/esd_queue.sv @@
`timescale 1ns / 1ps

module esd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  esd_pkg::dec_result_type   push_data,
   input  logic                      pop_ready,
   output logic                      pop_valid,
   output esd_pkg::rsp_item_type     pop_data,
   output esd_pkg::queue_status_type status
);
   import esd_pkg::*;

   rsp_item_type data_ff [QUEUE_DEPTH];
   rsp_item_type data_in [QUEUE_DEPTH];
   rsp_item_type shifted [QUEUE_DEPTH];
   rsp_item_type new_items [MAX_RESULTS];
   level_type    level_ff;
   level_type    level_in;
   level_type    base;
   level_type    push_cnt;
   level_type    offs;
   logic         pop;

   // Shift down by one entry on a pop.
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
         shifted[i] = data_ff[i + 1];
      end
      shifted[QUEUE_DEPTH-1] = data_ff[QUEUE_DEPTH-1];
   end

   // Tag the final byte of the text on the last pushed entry.
   always_comb begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         new_items[k].char_out    = push_data.chars[k];
         new_items[k].end_of_text = push_data.eot
                                    && (2'(k) == 2'(push_data.count - 2'd1));
      end
   end

   // Append the new bytes behind whatever remains after the pop.
   always_comb begin
      pop      = (level_ff != '0) && pop_ready;
      base     = level_ff - {2'b0, pop};
      push_cnt = push ? {1'b0, push_data.count} : '0;
      level_in = base + push_cnt;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         offs = 3'(i) - base;
         if ((3'(i) >= base) && (offs < push_cnt)) begin
            data_in[i] = new_items[offs[1:0]];
         end else if (pop) begin
            data_in[i] = shifted[i];
         end else begin
            data_in[i] = data_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         data_ff[i] <= data_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else begin
         level_ff <= level_in;
      end
   end

   assign pop_valid    = (level_ff != '0);
   assign pop_data     = data_ff[0];
   assign status.level = level_ff;
   assign status.ready = (level_ff <= 3'd1);

endmodule

@@ sv/escape_sequence_decoder.sv @@
`timescale 1ns / 1ps

// Channel   Role    Payload                 Meaning
// req       sink    char_in, is_last        raw text byte, last-byte flag
// rsp       source  char_out, end_of_text   translated byte, end-of-text flag
//
// One text byte is accepted per cycle while req.ready is high; its 0 to 3
// output bytes enter a registered 4-entry output queue and leave one per cycle
// while rsp.ready is high. req.ready is high while the queue holds at most one
// byte, so failed escapes (2 or 3 bytes out) stall input until it is down to one.
// Synchronous reset returns the parser to normal text mode and empties the queue.
// A stall on rsp holds the queue; input stops once two bytes are waiting.

module escape_sequence_decoder (
   input  logic              clock,
   input  logic              reset,
   esd_req_if.sink           req,
   esd_rsp_if.source         rsp
);
   import esd_pkg::*;

   parse_state_type  state_ff;
   parse_state_type  state_in;
   dec_result_type   dec_result;
   rsp_item_type     out_item;
   queue_status_type q_status;
   logic             accept;

   assign accept    = req.valid && req.ready;
   assign req.ready = q_status.ready;

   esd_decode u_decode (
      .state    (state_ff),
      .char_in  (req.char_in),
      .is_last  (req.is_last),
      .state_in (state_in),
      .result   (dec_result)
   );

   // Hold parser state until a transaction is accepted.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode        <= MODE_NORMAL;
         state_ff.held_first  <= '0;
         state_ff.held_second <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   esd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (dec_result),
      .pop_ready (rsp.ready),
      .pop_valid (rsp.valid),
      .pop_data  (out_item),
      .status    (q_status)
   );

   assign rsp.char_out    = out_item.char_out;
   assign rsp.end_of_text = out_item.end_of_text;

   // The queue never overfills.
   a_level_bound : assert property (@(posedge clock) disable iff (reset)
      q_status.level <= 3'(QUEUE_DEPTH))
      else $error("output queue overfilled");

   // The last byte of a text always yields at least one output byte.
   a_last_emits : assert property (@(posedge clock) disable iff (reset)
      (accept && req.is_last) |-> (dec_result.count != 2'd0))
      else $error("end of text produced no output");

   // End of text returns the parser to normal mode.
   a_last_resets : assert property (@(posedge clock) disable iff (reset)
      (accept && req.is_last) |=> (state_ff.mode == MODE_NORMAL))
      else $error("parser not flushed after end of text");

   // After bytes are emitted, rsp.valid is high in the next cycle.
   a_emit_visible : assert property (@(posedge clock) disable iff (reset)
      (accept && (dec_result.count != 2'd0)) |=> rsp.valid)
      else $error("emitted byte not presented");

endmodule
